// ===== rtl/obla_pkg.sv =====
package obla_pkg;

    localparam int ORD_DEPTH = 1024;
    localparam int LVL_DEPTH = 256;
    localparam int PRICE_BITS = 32;
    localparam int ORD_AW = $clog2(ORD_DEPTH);
    localparam int LVL_AW = $clog2(LVL_DEPTH);
    localparam int SCAN_MAX = (ORD_DEPTH > 2 * LVL_DEPTH) ? ORD_DEPTH : 2 * LVL_DEPTH;
    localparam int CNT_W = $clog2(SCAN_MAX + 1);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SNAP   = 2'd1,
        OP_NEW    = 2'd2,
        OP_CANCEL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_APPLIED = 2'd0,
        STS_STALE   = 2'd1,
        STS_IGNORED = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_OSCAN,
        S_ODEC,
        S_ADEC,
        S_LSCAN,
        S_LWRITE,
        S_OWRITE,
        S_BEST,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [47:0] sequence_req;
        logic [31:0] oid;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [31:0] best_bid_price;
        logic [31:0] best_bid_qty;
        logic [31:0] best_ask_price;
        logic [31:0] best_ask_qty;
        logic [8:0]  bid_level_count;
        logic [8:0]  ask_level_count;
    } t_out;

    typedef struct packed {
        logic                  valid;
        logic [31:0]           id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           qty;
    } t_ord;

    typedef struct packed {
        logic                  valid;
        logic [PRICE_BITS-1:0] price;
        logic [31:0]           qty;
    } t_lvl;

endpackage

// ===== rtl/obla_ram.sv =====
module obla_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/order_book_level_aggregator_unit.sv =====
// Channel   Handshake               Payload
// command   start / busy            i_item   (obla_pkg::t_in)
// result    o_valid, one cycle      o_result (obla_pkg::t_out)
//
// An order event makes a pass over the order memory (1024 reads), up to
// two passes over one side of the level memory (256 reads each) and a
// best-level pass over both sides (512 reads). A clear sweeps both
// memories; the same sweep runs after reset, with busy high. The result
// cannot be stalled.
module order_book_level_aggregator_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  obla_pkg::t_in  i_item,
    output logic           o_valid,
    output obla_pkg::t_out o_result
);
    import obla_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt, cm1;
    t_in r_in, n_in;
    logic [47:0] r_last_seq, n_last_seq;
    t_status r_status, n_status;
    logic [8:0] r_nb, n_nb, r_na, n_na;
    logic r_clr_out, n_clr_out;
    logic r_ohit, n_ohit, r_ofree_ok, n_ofree_ok;
    logic [ORD_AW-1:0] r_ohit_idx, n_ohit_idx, r_ofree_idx, n_ofree_idx, slot;
    logic r_m_side, n_m_side;
    logic [PRICE_BITS-1:0] r_m_price, n_m_price;
    logic [31:0] r_m_qty, n_m_qty;
    logic r_lside, n_lside, r_lrem, n_lrem;
    logic [PRICE_BITS-1:0] r_lprice, n_lprice;
    logic r_lhit, n_lhit, r_lfree_ok, n_lfree_ok;
    logic [LVL_AW-1:0] r_lhit_idx, n_lhit_idx, r_lfree_idx, n_lfree_idx;
    logic [31:0] r_lhit_qty, n_lhit_qty;
    logic r_hb, n_hb, r_ha, n_ha;
    logic [PRICE_BITS-1:0] r_bbp, n_bbp, r_bap, n_bap;
    logic [31:0] r_bbq, n_bbq, r_baq, n_baq;

    logic o_we, l_we;
    logic [ORD_AW-1:0] o_waddr, o_raddr;
    logic [LVL_AW:0] l_waddr, l_raddr;
    t_ord o_wdata, o_rdata;
    t_lvl l_wdata, l_rdata;

    logic accept, stale, scan_end;
    logic [32:0] sat_sum;

    obla_ram #(.DEPTH(ORD_DEPTH), .WIDTH($bits(t_ord))) u_ord_ram (
        .i_clk  (i_clk),
        .i_we   (o_we),
        .i_waddr(o_waddr),
        .i_wdata(o_wdata),
        .i_raddr(o_raddr),
        .o_rdata(o_rdata)
    );

    obla_ram #(.DEPTH(2 * LVL_DEPTH), .WIDTH($bits(t_lvl))) u_lvl_ram (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    assign busy = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign stale = (i_item.sequence_req != 48'd0) && (i_item.sequence_req <= r_last_seq);
    assign cm1 = r_cnt - CNT_W'(1);
    assign slot = (r_ohit && (!r_ofree_ok || r_ohit_idx < r_ofree_idx)) ? r_ohit_idx
                                                                          : r_ofree_idx;
    assign sat_sum = {1'b0, r_lhit_qty} + {1'b0, r_in.quantity};

    always_comb begin
        case (r_state)
            S_CLR:   scan_end = (r_cnt == CNT_W'(SCAN_MAX - 1));
            S_OSCAN: scan_end = (r_cnt == CNT_W'(ORD_DEPTH));
            S_LSCAN: scan_end = (r_cnt == CNT_W'(LVL_DEPTH));
            S_BEST:  scan_end = (r_cnt == CNT_W'(2 * LVL_DEPTH));
            default: scan_end = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (stale) begin
                        n_state = S_BEST;
                    end else begin
                        case (i_item.op)
                            OP_CLEAR: n_state = S_CLR;
                            OP_SNAP:  n_state = (i_item.quantity == 32'd0) ? S_BEST : S_LSCAN;
                            default:  n_state = (i_item.oid == 32'd0) ? S_BEST : S_OSCAN;
                        endcase
                    end
                end
            end
            S_CLR:   if (scan_end) n_state = r_clr_out ? S_BEST : S_IDLE;
            S_OSCAN: if (scan_end) n_state = S_ODEC;
            S_ODEC: begin
                if (r_in.op == OP_CANCEL && !r_ohit) begin
                    n_state = S_BEST;
                end else if (r_ohit) begin
                    n_state = S_LSCAN;
                end else begin
                    n_state = S_ADEC;
                end
            end
            S_ADEC: begin
                if (!(r_ofree_ok || r_ohit)) begin
                    n_state = S_BEST;
                end else if (r_in.quantity == 32'd0) begin
                    n_state = S_OWRITE;
                end else begin
                    n_state = S_LSCAN;
                end
            end
            S_LSCAN: if (scan_end) n_state = S_LWRITE;
            S_LWRITE: begin
                if (r_lrem) begin
                    n_state = (r_in.op == OP_NEW) ? S_ADEC : S_BEST;
                end else if (r_in.op == OP_NEW && (r_lhit || r_lfree_ok)) begin
                    n_state = S_OWRITE;
                end else begin
                    n_state = S_BEST;
                end
            end
            S_OWRITE: n_state = S_BEST;
            S_BEST:   if (scan_end) n_state = S_OUT;
            S_OUT:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_in = r_in;
        n_last_seq = r_last_seq;
        n_status = r_status;
        n_nb = r_nb;
        n_na = r_na;
        n_clr_out = r_clr_out;
        n_ohit = r_ohit;
        n_ohit_idx = r_ohit_idx;
        n_ofree_ok = r_ofree_ok;
        n_ofree_idx = r_ofree_idx;
        n_m_side = r_m_side;
        n_m_price = r_m_price;
        n_m_qty = r_m_qty;
        n_lside = r_lside;
        n_lprice = r_lprice;
        n_lrem = r_lrem;
        n_lhit = r_lhit;
        n_lhit_idx = r_lhit_idx;
        n_lhit_qty = r_lhit_qty;
        n_lfree_ok = r_lfree_ok;
        n_lfree_idx = r_lfree_idx;
        n_hb = r_hb;
        n_bbp = r_bbp;
        n_bbq = r_bbq;
        n_ha = r_ha;
        n_bap = r_bap;
        n_baq = r_baq;
        n_cnt = (n_state != r_state) ? '0 : r_cnt + CNT_W'(1);
        o_we = 1'b0;
        o_waddr = r_cnt[ORD_AW-1:0];
        o_wdata = '0;
        o_raddr = r_cnt[ORD_AW-1:0];
        l_we = 1'b0;
        l_waddr = r_cnt[LVL_AW:0];
        l_wdata = '0;
        l_raddr = {r_lside, r_cnt[LVL_AW-1:0]};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_in = i_item;
                    n_clr_out = 1'b1;
                    n_status = STS_APPLIED;
                    n_lside = i_item.side;
                    n_lprice = i_item.price[PRICE_BITS-1:0];
                    n_lrem = 1'b0;
                    if (stale) begin
                        n_status = STS_STALE;
                    end else begin
                        if (i_item.sequence_req != 48'd0) begin
                            n_last_seq = i_item.sequence_req;
                        end
                        if ((i_item.op == OP_NEW || i_item.op == OP_CANCEL)
                            && i_item.oid == 32'd0) begin
                            n_status = STS_IGNORED;
                        end
                        if (i_item.op == OP_CLEAR) begin
                            n_nb = '0;
                            n_na = '0;
                        end
                    end
                end
            end
            S_CLR: begin
                o_we = (r_cnt < CNT_W'(ORD_DEPTH));
                l_we = (r_cnt < CNT_W'(2 * LVL_DEPTH));
            end
            S_OSCAN: begin
                if (r_cnt == '0) begin
                    n_ohit = 1'b0;
                    n_ofree_ok = 1'b0;
                end else begin
                    if (o_rdata.valid && o_rdata.id == r_in.oid && !r_ohit) begin
                        n_ohit = 1'b1;
                        n_ohit_idx = cm1[ORD_AW-1:0];
                        n_m_side = o_rdata.side;
                        n_m_price = o_rdata.price;
                        n_m_qty = o_rdata.qty;
                    end
                    if (!o_rdata.valid && !r_ofree_ok) begin
                        n_ofree_ok = 1'b1;
                        n_ofree_idx = cm1[ORD_AW-1:0];
                    end
                end
            end
            S_ODEC: begin
                if (r_in.op == OP_CANCEL && !r_ohit) begin
                    n_status = STS_IGNORED;
                end else if (r_ohit) begin
                    o_we = 1'b1;
                    o_waddr = r_ohit_idx;
                    n_lside = r_m_side;
                    n_lprice = r_m_price;
                    n_lrem = 1'b1;
                end
            end
            S_ADEC: begin
                n_lside = r_in.side;
                n_lprice = r_in.price[PRICE_BITS-1:0];
                n_lrem = 1'b0;
                if (!(r_ofree_ok || r_ohit)) begin
                    n_status = STS_FULL;
                end
            end
            S_LSCAN: begin
                if (r_cnt == '0) begin
                    n_lhit = 1'b0;
                    n_lfree_ok = 1'b0;
                end else begin
                    if (l_rdata.valid && l_rdata.price == r_lprice && !r_lhit) begin
                        n_lhit = 1'b1;
                        n_lhit_idx = cm1[LVL_AW-1:0];
                        n_lhit_qty = l_rdata.qty;
                    end
                    if (!l_rdata.valid && !r_lfree_ok) begin
                        n_lfree_ok = 1'b1;
                        n_lfree_idx = cm1[LVL_AW-1:0];
                    end
                end
            end
            S_LWRITE: begin
                l_waddr = {r_lside, r_lhit ? r_lhit_idx : r_lfree_idx};
                l_wdata.price = r_lprice;
                if (r_lrem) begin
                    if (r_lhit) begin
                        l_we = 1'b1;
                        if (r_lhit_qty <= r_m_qty) begin
                            l_wdata.valid = 1'b0;
                            if (r_lside) n_na = r_na - 9'd1;
                            else n_nb = r_nb - 9'd1;
                        end else begin
                            l_wdata.valid = 1'b1;
                            l_wdata.qty = r_lhit_qty - r_m_qty;
                        end
                    end
                end else if (r_lhit) begin
                    l_we = 1'b1;
                    l_wdata.valid = 1'b1;
                    if (r_in.op == OP_SNAP) begin
                        l_wdata.qty = r_in.quantity;
                    end else begin
                        l_wdata.qty = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
                    end
                end else if (r_lfree_ok) begin
                    l_we = 1'b1;
                    l_wdata.valid = 1'b1;
                    l_wdata.qty = r_in.quantity;
                    if (r_lside) n_na = r_na + 9'd1;
                    else n_nb = r_nb + 9'd1;
                end else begin
                    n_status = STS_FULL;
                end
            end
            S_OWRITE: begin
                o_we = 1'b1;
                o_waddr = slot;
                o_wdata.valid = 1'b1;
                o_wdata.id = r_in.oid;
                o_wdata.side = r_in.side;
                o_wdata.price = r_in.price[PRICE_BITS-1:0];
                o_wdata.qty = r_in.quantity;
            end
            S_BEST: begin
                l_raddr = r_cnt[LVL_AW:0];
                if (r_cnt == '0) begin
                    n_hb = 1'b0;
                    n_bbp = '0;
                    n_bbq = '0;
                    n_ha = 1'b0;
                    n_bap = '0;
                    n_baq = '0;
                end else if (l_rdata.valid) begin
                    if (!cm1[LVL_AW]) begin
                        if (!r_hb || l_rdata.price > r_bbp) begin
                            n_hb = 1'b1;
                            n_bbp = l_rdata.price;
                            n_bbq = l_rdata.qty;
                        end
                    end else if (!r_ha || l_rdata.price < r_bap) begin
                        n_ha = 1'b1;
                        n_bap = l_rdata.price;
                        n_baq = l_rdata.qty;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cnt <= '0;
            r_last_seq <= '0;
            r_nb <= '0;
            r_na <= '0;
            r_clr_out <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_last_seq <= n_last_seq;
            r_nb <= n_nb;
            r_na <= n_na;
            r_clr_out <= n_clr_out;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        r_status <= n_status;
        r_ohit <= n_ohit;
        r_ohit_idx <= n_ohit_idx;
        r_ofree_ok <= n_ofree_ok;
        r_ofree_idx <= n_ofree_idx;
        r_m_side <= n_m_side;
        r_m_price <= n_m_price;
        r_m_qty <= n_m_qty;
        r_lside <= n_lside;
        r_lprice <= n_lprice;
        r_lrem <= n_lrem;
        r_lhit <= n_lhit;
        r_lhit_idx <= n_lhit_idx;
        r_lhit_qty <= n_lhit_qty;
        r_lfree_ok <= n_lfree_ok;
        r_lfree_idx <= n_lfree_idx;
        r_hb <= n_hb;
        r_bbp <= n_bbp;
        r_bbq <= n_bbq;
        r_ha <= n_ha;
        r_bap <= n_bap;
        r_baq <= n_baq;
    end

    assign o_valid = (r_state == S_OUT);
    assign o_result.status = r_status;
    assign o_result.best_bid_price = 32'(r_bbp);
    assign o_result.best_bid_qty = r_bbq;
    assign o_result.best_ask_price = 32'(r_bap);
    assign o_result.best_ask_qty = r_baq;
    assign o_result.bid_level_count = r_nb;
    assign o_result.ask_level_count = r_na;

endmodule

// ===== rtl/obla_checker.sv =====
module obla_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input obla_pkg::t_out o_result
);
    import obla_pkg::*;

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a transaction");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held for two cycles");

    a_empty_bid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.bid_level_count == 9'd0 |->
            o_result.best_bid_price == 32'd0 && o_result.best_bid_qty == 32'd0)
        else $error("best bid reported with no bid levels");

    a_empty_ask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.ask_level_count == 9'd0 |->
            o_result.best_ask_price == 32'd0 && o_result.best_ask_qty == 32'd0)
        else $error("best ask reported with no ask levels");

endmodule

bind order_book_level_aggregator_unit obla_checker u_obla_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_result(o_result)
);
